>>> design/tfvs_pkg.sv
`timescale 1ns / 1ps

package tfvs_pkg;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_OPEN   = 3'd1;
    localparam logic [2:0] PH_HOLD   = 3'd2;
    localparam logic [2:0] PH_CLOSE  = 3'd3;
    localparam logic [2:0] PH_SETTLE = 3'd4;

    localparam logic [1:0] MODE_COLD  = 2'd0;
    localparam logic [1:0] MODE_MIXED = 2'd1;
    localparam logic [1:0] MODE_HOT   = 2'd2;

    localparam logic [2:0] CFG_HAND_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_HOLD_MS        = 3'd1;
    localparam logic [2:0] CFG_CLOSE_MS       = 3'd2;
    localparam logic [2:0] CFG_SETTLE_MS      = 3'd3;
    localparam logic [2:0] CFG_FULL_POWER     = 3'd4;
    localparam logic [2:0] CFG_MIXED_POWER    = 3'd5;
    localparam logic [2:0] CFG_FULL_ANGLE     = 3'd6;
    localparam logic [2:0] CFG_MIXED_ANGLE    = 3'd7;

    localparam logic [6:0] POWER_MAX = 7'd100;

    typedef struct packed {
        logic               start_req;
        logic [1:0]         temp_mode;
        logic [7:0]         hand_distance;
        logic               estop;
        logic signed [15:0] hot_angle;
        logic signed [15:0] cold_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [7:0] hot_power;
        logic signed [7:0] cold_power;
        logic              zero_encoders;
        logic [2:0]        phase;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  hand_threshold;
        logic [15:0] hold_ms;
        logic [15:0] close_ms;
        logic [15:0] settle_ms;
        logic [6:0]  full_power;
        logic [6:0]  mixed_power;
        logic [11:0] full_angle;
        logic [11:0] mixed_angle;
    } t_cfg;

    typedef struct packed {
        logic [6:0]  hot_drive;
        logic [6:0]  cold_drive;
        logic [11:0] hot_target;
        logic [11:0] cold_target;
    } t_launch;

endpackage

>>> design/tfvs_mode_decode.sv
`timescale 1ns / 1ps

module tfvs_mode_decode
    import tfvs_pkg::*;
(
    input  logic [1:0] i_mode,
    input  t_cfg       i_cfg,
    output t_launch    o_launch
);

    logic [6:0] full_clamped;
    logic [6:0] mixed_clamped;

    assign full_clamped  = (i_cfg.full_power > POWER_MAX) ? POWER_MAX : i_cfg.full_power;
    assign mixed_clamped = (i_cfg.mixed_power > POWER_MAX) ? POWER_MAX : i_cfg.mixed_power;

    always_comb begin
        o_launch = '0;
        unique case (i_mode)
            MODE_COLD: begin
                o_launch.cold_drive  = full_clamped;
                o_launch.cold_target = i_cfg.full_angle;
            end
            MODE_MIXED: begin
                o_launch.hot_drive   = mixed_clamped;
                o_launch.hot_target  = i_cfg.mixed_angle;
                o_launch.cold_drive  = mixed_clamped;
                o_launch.cold_target = i_cfg.mixed_angle;
            end
            MODE_HOT: begin
                o_launch.hot_drive  = full_clamped;
                o_launch.hot_target = i_cfg.full_angle;
            end
            default: begin
                o_launch = '0;
            end
        endcase
    end

endmodule

>>> design/tfvs_core.sv
`timescale 1ns / 1ps

module tfvs_core
    import tfvs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    typedef enum logic [2:0] {
        S_IDLE   = PH_IDLE,
        S_OPEN   = PH_OPEN,
        S_HOLD   = PH_HOLD,
        S_CLOSE  = PH_CLOSE,
        S_SETTLE = PH_SETTLE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_tick, n_tick;
    logic [6:0]  r_hot_drive, n_hot_drive;
    logic [6:0]  r_cold_drive, n_cold_drive;
    logic [11:0] r_hot_target, n_hot_target;
    logic [11:0] r_cold_target, n_cold_target;
    t_out_item   r_result, n_result;

    t_launch     launch;
    logic [15:0] hot_mag;
    logic [15:0] cold_mag;
    logic [15:0] tick_inc;
    logic        zero_enc;
    logic        targets_met;
    logic        hand_seen;

    tfvs_mode_decode u_mode_decode (
        .i_mode   (i_item.temp_mode),
        .i_cfg    (i_cfg),
        .o_launch (launch)
    );

    assign hot_mag  = i_item.hot_angle[15] ? 16'(-i_item.hot_angle) : i_item.hot_angle;
    assign cold_mag = i_item.cold_angle[15] ? 16'(-i_item.cold_angle) : i_item.cold_angle;
    assign targets_met = (hot_mag >= {4'd0, r_hot_target})
                      && (cold_mag >= {4'd0, r_cold_target});
    assign hand_seen = i_item.hand_distance < i_cfg.hand_threshold;
    assign tick_inc  = r_tick + 16'd1;

    always_comb begin
        n_phase       = r_phase;
        n_tick        = r_tick;
        n_hot_drive   = r_hot_drive;
        n_cold_drive  = r_cold_drive;
        n_hot_target  = r_hot_target;
        n_cold_target = r_cold_target;
        zero_enc      = 1'b0;
        unique case (r_phase)
            S_IDLE: begin
                if (i_item.start_req) begin
                    n_hot_drive   = launch.hot_drive;
                    n_cold_drive  = launch.cold_drive;
                    n_hot_target  = launch.hot_target;
                    n_cold_target = launch.cold_target;
                    zero_enc      = 1'b1;
                    n_tick        = '0;
                    n_phase       = S_OPEN;
                end
            end
            S_OPEN: begin
                if (i_item.estop || targets_met) begin
                    n_tick  = '0;
                    n_phase = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_item.estop) begin
                    n_tick  = '0;
                    n_phase = S_CLOSE;
                end else if (hand_seen) begin
                    n_tick = '0;
                end else if (tick_inc >= i_cfg.hold_ms) begin
                    n_tick  = '0;
                    n_phase = S_CLOSE;
                end else begin
                    n_tick = tick_inc;
                end
            end
            S_CLOSE: begin
                if (tick_inc >= i_cfg.close_ms) begin
                    n_tick  = '0;
                    n_phase = S_SETTLE;
                end else begin
                    n_tick = tick_inc;
                end
            end
            S_SETTLE: begin
                if (tick_inc >= i_cfg.settle_ms) begin
                    n_tick  = '0;
                    n_phase = S_IDLE;
                end else begin
                    n_tick = tick_inc;
                end
            end
            default: begin
                n_tick  = '0;
                n_phase = S_IDLE;
            end
        endcase

        n_result.zero_encoders = zero_enc;
        n_result.phase         = n_phase;
        if (n_phase == S_OPEN) begin
            n_result.hot_power  = {1'b0, n_hot_drive};
            n_result.cold_power = {1'b0, n_cold_drive};
        end else if (n_phase == S_CLOSE) begin
            n_result.hot_power  = 8'(8'd0 - {1'b0, n_hot_drive});
            n_result.cold_power = 8'(8'd0 - {1'b0, n_cold_drive});
        end else begin
            n_result.hot_power  = '0;
            n_result.cold_power = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= S_IDLE;
            r_tick        <= '0;
            r_hot_drive   <= '0;
            r_cold_drive  <= '0;
            r_hot_target  <= '0;
            r_cold_target <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_tick        <= n_tick;
            r_hot_drive   <= n_hot_drive;
            r_cold_drive  <= n_cold_drive;
            r_hot_target  <= n_hot_target;
            r_cold_target <= n_cold_target;
            r_result      <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

>>> design/touchless_faucet_valve_sequencer.sv
`timescale 1ns / 1ps

// Valve sequencer for a hot and a cold motor-driven faucet handle, one request per 1 ms
// tick. Requests are taken one per clock cycle when the result side keeps up: a request
// is latched in the input register, stepped through the phase logic in one pass and its
// result lands in the result register once that register is free, to be taken by the
// consumer. Throughput is bounded only by the result register draining; a
// waiting result lets one more request into the input register and then holds the input
// off until that result is taken. Configuration is a plain indexed write port (index 0
// hand_threshold through 7 mixed_angle) and should be written only while no request is
// in flight.
module touchless_faucet_valve_sequencer
    import tfvs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cfg     r_cfg;
    t_in_item r_in_item;
    logic     r_in_valid;
    logic     r_out_valid;
    logic     out_free;
    logic     step;

    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hand_threshold <= 8'd20;
            r_cfg.hold_ms        <= 16'd2000;
            r_cfg.close_ms       <= 16'd1100;
            r_cfg.settle_ms      <= 16'd500;
            r_cfg.full_power     <= 7'd35;
            r_cfg.mixed_power    <= 7'd30;
            r_cfg.full_angle     <= 12'd140;
            r_cfg.mixed_angle    <= 12'd100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HAND_THRESHOLD: r_cfg.hand_threshold <= i_cfg_data[7:0];
                CFG_HOLD_MS:        r_cfg.hold_ms        <= i_cfg_data;
                CFG_CLOSE_MS:       r_cfg.close_ms       <= i_cfg_data;
                CFG_SETTLE_MS:      r_cfg.settle_ms      <= i_cfg_data;
                CFG_FULL_POWER:     r_cfg.full_power     <= i_cfg_data[6:0];
                CFG_MIXED_POWER:    r_cfg.mixed_power    <= i_cfg_data[6:0];
                CFG_FULL_ANGLE:     r_cfg.full_angle     <= i_cfg_data[11:0];
                CFG_MIXED_ANGLE:    r_cfg.mixed_angle    <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    tfvs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (o_out_item)
    );

    assign o_out_valid = r_out_valid;

    // encoder zeroing is only requested on the tick that enters opening
    a_zero_in_open : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_out_item.zero_encoders) |-> (o_out_item.phase == PH_OPEN))
        else $error("zero_encoders outside opening phase");

    // motors move only while opening or closing
    a_power_phase : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (o_out_item.hot_power != 8'sd0 || o_out_item.cold_power != 8'sd0))
        |-> (o_out_item.phase == PH_OPEN || o_out_item.phase == PH_CLOSE))
        else $error("motor power outside drive phases");

    // a stalled result keeps the input side stalled only once the input register fills
    a_ready_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a full pipeline");

    // a result taken with a request behind it is replaced in the next cycle
    a_refill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_free) |=> r_out_valid)
        else $error("stepped request produced no result");

endmodule
